### rtl/bsxfc_pkg.sv
// bsxfc_pkg: shared constants for the sync/xor frame checker
// register indexes, reset values, result codes and field widths
// no dependencies
`default_nettype none

package bsxfc_pkg;

    localparam int OFFSET_W   = 20;
    localparam int WORD_W     = 32;
    localparam int TYPE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PATTERN_W  = 16;
    localparam int COUNT_W    = 14;

    localparam int DEF_MAX_DATA_WORDS = 8192;
    localparam int DEF_OFFSET_BITS    = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_PATTERN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_HEADER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_XOR_SUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_WORD_COUNT  = 3'd4;

    localparam logic [PATTERN_W-1:0]  RST_SYNC_PATTERN     = 16'h4429;
    localparam logic [PATTERN_W-1:0]  RST_PAD_PATTERN      = 16'h5552;
    localparam logic [PATTERN_W-1:0]  RST_EXPECTED_HEADER  = 16'h61d0;
    localparam logic [WORD_W-1:0]     RST_EXPECTED_XOR_SUM = 32'h1917bf6b;
    localparam logic [COUNT_W-1:0]    RST_DATA_WORD_COUNT  = 14'd3147;

    // result item types
    localparam logic [TYPE_W-1:0] ITEM_HEADER     = 2'd0;
    localparam logic [TYPE_W-1:0] ITEM_DATA       = 2'd1;
    localparam logic [TYPE_W-1:0] ITEM_STREAM_END = 2'd2;

    // input kinds
    localparam logic KIND_BIT = 1'b0;
    localparam logic KIND_END = 1'b1;

    // odd/even mfm bit mask
    localparam logic [PATTERN_W-1:0] MFM_MASK = 16'h5555;

    // the sync word's first bit lies this many bits before the completing bit
    localparam int SYNC_SPAN = 15;

endpackage

`default_nettype wire

### rtl/bsxfc_if.sv
// bsxfc_bit_if / bsxfc_res_if: valid/ready channels of the frame checker
// depends on bsxfc_pkg for field widths
`default_nettype none

interface bsxfc_bit_if
    import bsxfc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                kind;
    logic                raw_bit;
    logic [OFFSET_W-1:0] track_bit_offset;

    modport source (output valid, output kind, output raw_bit, output track_bit_offset,
                    input ready);
    modport sink   (input valid, input kind, input raw_bit, input track_bit_offset,
                    output ready);
endinterface

interface bsxfc_res_if
    import bsxfc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   item_type;
    logic [WORD_W-1:0]   word;
    logic [OFFSET_W-1:0] sync_bit_offset;
    logic                last;
    logic                sum_ok;

    modport source (output valid, output item_type, output word, output sync_bit_offset,
                    output last, output sum_ok, input ready);
    modport sink   (input valid, input item_type, input word, input sync_bit_offset,
                    input last, input sum_ok, output ready);
endinterface

`default_nettype wire

### rtl/bitstream_sync_xor_frame_checker_unit.sv
// bitstream_sync_xor_frame_checker_unit: bit-serial sync hunt, header check and xor frame check
// depends on bsxfc_pkg and the channel interfaces in bsxfc_if.sv
//
//   channel    dir   handshake        payload
//   in_item    in    valid/ready      kind, raw_bit, track_bit_offset
//   out_item   out   valid/ready      item_type, word, sync_bit_offset, last, sum_ok
//   cfg        in    cfg_write        cfg_index, cfg_data
//
// one bit item per cycle while in_item is ready; all state moves at the accepting edge and the result
// shows from the result register in the cycle after
// in_item is held off only while a result waits and out_item is not ready
// rst_n clears window, phase, counters and result valid; registers return to defaults
// after a good frame every item is taken and dropped until the next reset
`default_nettype none

module bitstream_sync_xor_frame_checker_unit
    import bsxfc_pkg::*;
#(
    parameter int MAX_DATA_WORDS = DEF_MAX_DATA_WORDS,
    parameter int OFFSET_BITS    = DEF_OFFSET_BITS
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    bsxfc_bit_if.sink            in_item,
    bsxfc_res_if.source          out_item,
    input  wire                  cfg_write,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data
);

    localparam int SAVED_W = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
    localparam int CNT_W   = (MAX_DATA_WORDS > 1) ? $clog2(MAX_DATA_WORDS) : 1;
    localparam int CMP_W   = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 2;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_PAD    = 3'd1;
    localparam logic [2:0] PH_HEADER = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [4:0] PAD_LAST  = 5'd15;
    localparam logic [4:0] WORD_LAST = 5'd31;

    // configuration
    logic [PATTERN_W-1:0] sync_pattern_reg;
    logic [PATTERN_W-1:0] pad_pattern_reg;
    logic [PATTERN_W-1:0] expected_header_reg;
    logic [WORD_W-1:0]    expected_xor_sum_reg;
    logic [COUNT_W-1:0]   data_word_count_reg;

    // frame state
    logic [31:0]        bit_window_reg,  bit_window_next;
    logic [2:0]         phase_reg,       phase_next;
    logic [4:0]         bit_count_reg,   bit_count_next;
    logic [CNT_W-1:0]   word_count_reg,  word_count_next;
    logic [WORD_W-1:0]  xor_acc_reg,     xor_acc_next;
    logic [SAVED_W-1:0] sync_offset_reg, sync_offset_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]   out_type_reg,  out_type_next;
    logic [WORD_W-1:0]   out_word_reg,  out_word_next;
    logic [OFFSET_W-1:0] out_off_reg,   out_off_next;
    logic                out_last_reg,  out_last_next;
    logic                out_ok_reg,    out_ok_next;

    logic                 accept;
    logic                 emit;
    logic [31:0]          shifted;
    logic [PATTERN_W-1:0] header;
    logic [CMP_W-1:0]     eff_count;
    logic [CMP_W-1:0]     words_done;
    logic                 final_word;
    logic                 sum_match;

    assign in_item.ready = !out_valid_reg || out_item.ready;
    assign accept        = in_item.valid && in_item.ready;

    assign out_item.valid           = out_valid_reg;
    assign out_item.item_type       = out_type_reg;
    assign out_item.word            = out_word_reg;
    assign out_item.sync_bit_offset = out_off_reg;
    assign out_item.last            = out_last_reg;
    assign out_item.sum_ok          = out_ok_reg;

    assign shifted = {bit_window_reg[30:0], in_item.raw_bit};
    assign header  = ((shifted[31:16] & MFM_MASK) << 1) | (shifted[15:0] & MFM_MASK);

    // word count clamped to 1..MAX_DATA_WORDS
    always_comb
    begin
        eff_count = CMP_W'(data_word_count_reg);
        if (data_word_count_reg == '0)
        begin
            eff_count = CMP_W'(1);
        end
        else if (CMP_W'(data_word_count_reg) > CMP_W'(MAX_DATA_WORDS))
        begin
            eff_count = CMP_W'(MAX_DATA_WORDS);
        end
    end

    assign words_done = CMP_W'(word_count_reg) + CMP_W'(1);
    assign final_word = words_done >= eff_count;
    assign sum_match  = (xor_acc_reg ^ shifted) == expected_xor_sum_reg;

    always_comb
    begin
        bit_window_next  = bit_window_reg;
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        word_count_next  = word_count_reg;
        xor_acc_next     = xor_acc_reg;
        sync_offset_next = sync_offset_reg;
        emit             = 1'b0;
        out_type_next    = out_type_reg;
        out_word_next    = out_word_reg;
        out_off_next     = out_off_reg;
        out_last_next    = out_last_reg;
        out_ok_next      = out_ok_reg;

        if (accept && phase_reg != PH_DONE)
        begin
            if (in_item.kind == KIND_END)
            begin
                bit_window_next = '0;
                phase_next      = PH_HUNT;
                bit_count_next  = '0;
                word_count_next = '0;
                xor_acc_next    = '0;
                emit            = 1'b1;
                out_type_next   = ITEM_STREAM_END;
                out_word_next   = '0;
                out_off_next    = '0;
                out_last_next   = 1'b0;
                out_ok_next     = 1'b0;
            end
            else
            begin
                bit_window_next = shifted;
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (shifted[15:0] == sync_pattern_reg)
                        begin
                            sync_offset_next = in_item.track_bit_offset[SAVED_W-1:0]
                                               - SAVED_W'(SYNC_SPAN);
                            phase_next       = PH_PAD;
                            bit_count_next   = '0;
                        end
                    end
                    PH_PAD:
                    begin
                        if (bit_count_reg == PAD_LAST)
                        begin
                            bit_count_next = '0;
                            phase_next     = (shifted[15:0] == pad_pattern_reg) ? PH_HEADER
                                                                                : PH_HUNT;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 5'd1;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (bit_count_reg != WORD_LAST)
                        begin
                            bit_count_next = bit_count_reg + 5'd1;
                        end
                        else
                        begin
                            bit_count_next = '0;
                            if (header != expected_header_reg)
                            begin
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                phase_next      = PH_DATA;
                                word_count_next = '0;
                                xor_acc_next    = '0;
                                emit            = 1'b1;
                                out_type_next   = ITEM_HEADER;
                                out_word_next   = WORD_W'(header);
                                out_off_next    = OFFSET_W'(sync_offset_reg);
                                out_last_next   = 1'b0;
                                out_ok_next     = 1'b0;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (bit_count_reg != WORD_LAST)
                        begin
                            bit_count_next = bit_count_reg + 5'd1;
                        end
                        else
                        begin
                            bit_count_next = '0;
                            xor_acc_next   = xor_acc_reg ^ shifted;
                            emit           = 1'b1;
                            out_type_next  = ITEM_DATA;
                            out_word_next  = shifted;
                            out_off_next   = OFFSET_W'(sync_offset_reg);
                            out_last_next  = final_word;
                            out_ok_next    = final_word && sum_match;
                            if (final_word)
                            begin
                                phase_next      = sum_match ? PH_DONE : PH_HUNT;
                                word_count_next = '0;
                            end
                            else
                            begin
                                word_count_next = word_count_reg + CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        phase_next     = PH_HUNT;
                        bit_count_next = '0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = emit;
        end
        else if (out_item.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_window_reg  <= '0;
            phase_reg       <= PH_HUNT;
            bit_count_reg   <= '0;
            word_count_reg  <= '0;
            xor_acc_reg     <= '0;
            sync_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bit_window_reg  <= bit_window_next;
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            word_count_reg  <= word_count_next;
            xor_acc_reg     <= xor_acc_next;
            sync_offset_reg <= sync_offset_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_type_reg <= out_type_next;
            out_word_reg <= out_word_next;
            out_off_reg  <= out_off_next;
            out_last_reg <= out_last_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg     <= RST_SYNC_PATTERN;
            pad_pattern_reg      <= RST_PAD_PATTERN;
            expected_header_reg  <= RST_EXPECTED_HEADER;
            expected_xor_sum_reg <= RST_EXPECTED_XOR_SUM;
            data_word_count_reg  <= RST_DATA_WORD_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_PATTERN:     sync_pattern_reg     <= cfg_data[PATTERN_W-1:0];
                REG_PAD_PATTERN:      pad_pattern_reg      <= cfg_data[PATTERN_W-1:0];
                REG_EXPECTED_HEADER:  expected_header_reg  <= cfg_data[PATTERN_W-1:0];
                REG_EXPECTED_XOR_SUM: expected_xor_sum_reg <= cfg_data[WORD_W-1:0];
                REG_DATA_WORD_COUNT:  data_word_count_reg  <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
